// ----- rtl/core/lpd_pkg.sv -----
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants for the length-prefixed deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

  localparam int HEADER_BYTES = 5;
  localparam int LEN_BYTES    = 4;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_TOKLEN = 2'd1,
    PH_DATA   = 2'd2,
    PH_SKIP   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_TYPE    = 2'd0,
    KIND_BYTE    = 2'd1,
    KIND_EMPTY   = 2'd2,
    KIND_CORRUPT = 2'd3
  } kind_t;

  typedef struct packed {
    logic       present;
    kind_t      kind;
    logic [7:0] value;
    logic [7:0] token_index;
    logic       token_last;
    logic       message_last;
  } result_t;

endpackage

// ----- rtl/core/length_prefixed_deframer.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_deframer
// Splits a byte stream of length-prefixed messages into typed, indexed
// token bytes with end-of-token and end-of-message marks.
//
//   channel  signals                      width  content
//   in       in_valid / in_ready          8      stream_byte
//   out      out_valid / out_ready        20     kind, value, token_index,
//                                                token_last, message_last
//
// One byte per cycle sustained, unless a blocked result stalls the input stage.
// Each byte passes an input register, one decode step, and a result register.
// Bytes that produce no result drain even while the result register is full.
// Reset is synchronous and returns the parser to the header phase.
// A full result register with out_ready low holds the input stage for a byte that produces a result.
// ----------------------------------------------------------------------------
module length_prefixed_deframer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] stream_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] value,
  output logic [7:0] token_index,
  output logic       token_last,
  output logic       message_last
);

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             advance;
  lpd_pkg::result_t res;

  assign advance  = s1_valid && (!res.present || !out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  lpd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .stream_byte (s1_byte),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= stream_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.present) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.present) begin
      kind         <= res.kind;
      value        <= res.value;
      token_index  <= res.token_index;
      token_last   <= res.token_last;
      message_last <= res.message_last;
    end
  end

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  a_type_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == lpd_pkg::KIND_TYPE |-> token_index == 8'd0 && !token_last)
    else $error("type request carries token marks");

  a_corrupt_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == lpd_pkg::KIND_CORRUPT |-> message_last && !token_last
      && value == 8'd0)
    else $error("corrupt request does not end message");

  a_empty_tok: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == lpd_pkg::KIND_EMPTY |-> token_last && value == 8'd0)
    else $error("empty token request malformed");

endmodule

// ----- rtl/core/lpd_parser.sv -----
// ----------------------------------------------------------------------------
// lpd_parser
// Framing state and per-byte decode: headers, token lengths, payload, skip.
// ----------------------------------------------------------------------------
module lpd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [7:0]        stream_byte,
  output lpd_pkg::result_t  res
);

  lpd_pkg::phase_t phase, phase_next;
  logic [2:0]      field_byte_count, field_byte_count_next;
  logic [31:0]     length_shift, length_shift_next;
  logic [30:0]     body_remaining, body_remaining_next;
  logic [31:0]     token_remaining, token_remaining_next;
  logic [7:0]      token_count, token_count_next;
  logic [7:0]      type_hold, type_hold_next;

  logic [30:0] body_dec;
  logic [31:0] token_dec;
  logic [31:0] shifted;
  logic [7:0]  count_bump;
  logic        body_done;
  logic        tok_last;

  assign body_dec   = body_remaining - 31'd1;
  assign token_dec  = token_remaining - 32'd1;
  assign shifted    = {length_shift[23:0], stream_byte};
  assign count_bump = (token_count == 8'hFF) ? token_count : token_count + 8'd1;
  assign body_done  = (body_dec == 31'd0);
  assign tok_last   = (token_dec == 32'd0);

  always_comb begin
    phase_next            = phase;
    field_byte_count_next = field_byte_count;
    length_shift_next     = length_shift;
    body_remaining_next   = body_remaining;
    token_remaining_next  = token_remaining;
    token_count_next      = token_count;
    type_hold_next        = type_hold;
    res                   = '0;
    res.token_index       = token_count;

    unique case (phase)
      lpd_pkg::PH_TOKLEN: begin
        body_remaining_next = body_dec;
        length_shift_next   = shifted;
        if (field_byte_count < 3'(lpd_pkg::LEN_BYTES - 1)) begin
          field_byte_count_next = field_byte_count + 3'd1;
          if (body_done) begin
            res.present           = 1'b1;
            res.kind              = lpd_pkg::KIND_CORRUPT;
            res.message_last      = 1'b1;
            phase_next            = lpd_pkg::PH_HEADER;
            field_byte_count_next = 3'd0;
          end
        end else begin
          field_byte_count_next = 3'd0;
          if (shifted > {1'b0, body_dec}) begin
            res.present      = 1'b1;
            res.kind         = lpd_pkg::KIND_CORRUPT;
            res.message_last = 1'b1;
            phase_next       = body_done ? lpd_pkg::PH_HEADER : lpd_pkg::PH_SKIP;
          end else if (shifted == 32'd0) begin
            res.present      = 1'b1;
            res.kind         = lpd_pkg::KIND_EMPTY;
            res.token_last   = 1'b1;
            res.message_last = body_done;
            token_count_next = count_bump;
            phase_next       = body_done ? lpd_pkg::PH_HEADER : lpd_pkg::PH_TOKLEN;
          end else begin
            token_remaining_next = shifted;
            phase_next           = lpd_pkg::PH_DATA;
          end
        end
      end
      lpd_pkg::PH_DATA: begin
        body_remaining_next  = body_dec;
        token_remaining_next = token_dec;
        res.present          = 1'b1;
        res.kind             = lpd_pkg::KIND_BYTE;
        res.value            = stream_byte;
        res.token_last       = tok_last;
        res.message_last     = tok_last && body_done;
        if (tok_last) begin
          token_count_next      = count_bump;
          field_byte_count_next = 3'd0;
          phase_next            = body_done ? lpd_pkg::PH_HEADER : lpd_pkg::PH_TOKLEN;
        end
      end
      lpd_pkg::PH_SKIP: begin
        body_remaining_next = body_dec;
        if (body_done) begin
          phase_next = lpd_pkg::PH_HEADER;
        end
      end
      default: begin
        phase_next = lpd_pkg::PH_HEADER;
        if (field_byte_count == 3'd0) begin
          type_hold_next        = stream_byte;
          length_shift_next     = 32'd0;
          field_byte_count_next = 3'd1;
        end else begin
          length_shift_next = shifted;
          if (field_byte_count < 3'(lpd_pkg::HEADER_BYTES - 1)) begin
            field_byte_count_next = field_byte_count + 3'd1;
          end else begin
            field_byte_count_next = 3'd0;
            token_count_next      = 8'd0;
            token_remaining_next  = 32'd0;
            body_remaining_next   = shifted[31] ? 31'd0 : shifted[30:0];
            res.present           = 1'b1;
            res.kind              = lpd_pkg::KIND_TYPE;
            res.value             = type_hold;
            res.token_index       = 8'd0;
            res.message_last      = (body_remaining_next == 31'd0);
            phase_next            = (body_remaining_next == 31'd0) ?
                                    lpd_pkg::PH_HEADER : lpd_pkg::PH_TOKLEN;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= lpd_pkg::PH_HEADER;
      field_byte_count <= 3'd0;
      length_shift     <= 32'd0;
      body_remaining   <= 31'd0;
      token_remaining  <= 32'd0;
      token_count      <= 8'd0;
      type_hold        <= 8'd0;
    end else if (advance) begin
      phase            <= phase_next;
      field_byte_count <= field_byte_count_next;
      length_shift     <= length_shift_next;
      body_remaining   <= body_remaining_next;
      token_remaining  <= token_remaining_next;
      token_count      <= token_count_next;
      type_hold        <= type_hold_next;
    end
  end

endmodule
